FILE: design/u8cw_pkg.sv
// ----------------------------------------------------------------------------
// u8cw_pkg: shared types and constants for the UTF-8 coercion block
// Holds the work entry that passes from the classifier to the serialiser,
// and the default depth of the queue between them.
// ----------------------------------------------------------------------------
package u8cw_pkg;

  // Most output bytes that one input byte can cause: a replacement for a
  // broken sequence, then a replacement for a bad lead byte or for an
  // unfinished string end.
  localparam int unsigned MAX_RUN     = 6;
  localparam int unsigned RUN_W       = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  // One request's worth of output bytes, in order, and how many are live.
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [RUN_W-1:0]        count;
    logic                    last;
  } entry_t;

endpackage

FILE: design/u8cw_front.sv
// ----------------------------------------------------------------------------
// u8cw_front: byte classifier and sequence tracker
// Checks each input byte against the pending sequence, updates the held
// bytes and builds the list of output bytes that the byte causes.
// ----------------------------------------------------------------------------
module u8cw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output logic              push_o,
  output u8cw_pkg::entry_t  entry_o,
  input  logic              full_i
);
  import u8cw_pkg::*;

  localparam logic [7:0] Repl0 = 8'hEF;
  localparam logic [7:0] Repl1 = 8'hBF;
  localparam logic [7:0] Repl2 = 8'hBD;

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic [2:0]      seq_len_q, seq_len_d;

  logic [MAX_RUN-1:0][7:0] obuf;
  logic [RUN_W-1:0]        n;
  logic                    start;
  logic                    trail_ok;
  logic [7:0]              lo, hi;
  logic [2:0]              lead_len;
  logic                    accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Second-byte limits only after the lead byte alone is held.
  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    if (held_cnt_q == 2'd1) begin
      case (held_q[0])
        8'hE0:   lo = 8'hA0;
        8'hED:   hi = 8'h9F;
        8'hF0:   lo = 8'h90;
        8'hF4:   hi = 8'h8F;
        default: ;
      endcase
    end
    trail_ok = (in_byte_i >= lo) && (in_byte_i <= hi);
  end

  always_comb begin
    if (in_byte_i >= 8'hC2 && in_byte_i <= 8'hDF) begin
      lead_len = 3'd2;
    end else if (in_byte_i >= 8'hE0 && in_byte_i <= 8'hEF) begin
      lead_len = 3'd3;
    end else if (in_byte_i >= 8'hF0 && in_byte_i <= 8'hF4) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  always_comb begin
    obuf       = '0;
    n          = '0;
    start      = 1'b0;
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    seq_len_d  = seq_len_q;

    if (held_cnt_q != 2'd0) begin
      if (trail_ok) begin
        if (({1'b0, held_cnt_q} + 3'd1) == seq_len_q) begin
          for (int i = 0; i < 3; i++) begin
            if (i < int'(held_cnt_q)) begin
              obuf[n] = held_q[i];
              n = n + RUN_W'(1);
            end
          end
          obuf[n] = in_byte_i;
          n = n + RUN_W'(1);
          held_cnt_d = 2'd0;
          seq_len_d  = 3'd0;
        end else begin
          held_d[held_cnt_q] = in_byte_i;
          held_cnt_d = held_cnt_q + 2'd1;
        end
      end else begin
        // Flush the broken sequence, then treat the byte as a fresh start.
        obuf[n] = Repl0; n = n + RUN_W'(1);
        obuf[n] = Repl1; n = n + RUN_W'(1);
        obuf[n] = Repl2; n = n + RUN_W'(1);
        start = 1'b1;
      end
    end else begin
      start = 1'b1;
    end

    if (start) begin
      held_cnt_d = 2'd0;
      seq_len_d  = 3'd0;
      if (!in_byte_i[7]) begin
        obuf[n] = in_byte_i;
        n = n + RUN_W'(1);
      end else if (lead_len != 3'd0) begin
        held_d[0]  = in_byte_i;
        held_cnt_d = 2'd1;
        seq_len_d  = lead_len;
      end else begin
        obuf[n] = Repl0; n = n + RUN_W'(1);
        obuf[n] = Repl1; n = n + RUN_W'(1);
        obuf[n] = Repl2; n = n + RUN_W'(1);
      end
    end

    if (in_last_i) begin
      if (held_cnt_d != 2'd0) begin
        obuf[n] = Repl0; n = n + RUN_W'(1);
        obuf[n] = Repl1; n = n + RUN_W'(1);
        obuf[n] = Repl2; n = n + RUN_W'(1);
      end
      held_cnt_d = 2'd0;
      seq_len_d  = 3'd0;
    end
  end

  // A byte that only extends a sequence causes nothing downstream.
  assign push_o        = accept && (n != '0);
  assign entry_o.bytes = obuf;
  assign entry_o.count = n;
  assign entry_o.last  = in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      seq_len_q  <= 3'd0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
      seq_len_q  <= seq_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

FILE: design/u8cw_queue.sv
// ----------------------------------------------------------------------------
// u8cw_queue: request queue between classifier and serialiser
// A small register FIFO; full stalls the front, empty idles the back.
// ----------------------------------------------------------------------------
module u8cw_queue #(
  parameter int unsigned Depth = u8cw_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8cw_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output u8cw_pkg::entry_t  head_o
);
  import u8cw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntFull);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: design/u8cw_back.sv
// ----------------------------------------------------------------------------
// u8cw_back: output serialiser
// Walks the head request one byte per handshake and retires it on the last.
// ----------------------------------------------------------------------------
module u8cw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  u8cw_pkg::entry_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  output logic              string_last_o
);
  import u8cw_pkg::*;

  logic [RUN_W-1:0] idx_q, idx_d;
  logic             fire;

  assign out_valid_o   = head_valid_i;
  assign out_byte_o    = head_i.bytes[idx_q];
  assign run_last_o    = (idx_q == (head_i.count - RUN_W'(1)));
  assign string_last_o = run_last_o && head_i.last;
  assign fire          = out_valid_o && out_ready_i;
  assign pop_o         = fire && run_last_o;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = run_last_o ? '0 : idx_q + RUN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

FILE: design/utf8_coerce_to_wellformed.sv
// ----------------------------------------------------------------------------
// utf8_coerce_to_wellformed: UTF-8 validation with replacement character
// Passes well-formed UTF-8 through and replaces each maximal ill-formed
// subpart, bad lead byte and unfinished tail with EF BF BD.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_byte_i, in_last_i
//  out     | output    | out_valid_o/out_ready_i| out_byte_o, run_last_o,
//          |           |                        | string_last_o
//
//  One input byte is accepted per cycle while the request queue has room.
//  A byte that causes k output bytes (k from 0 to 6) takes k handshakes;
//  the serialiser's one byte per cycle while out_ready_i is high sets the
//  output rate. Results pass through the request queue to the port.
//  Reset clears the pending sequence, the queue and the serialiser index.
//  Output stalls back up through the queue; when it fills, in_ready_o drops.
//
module utf8_coerce_to_wellformed #(
  parameter int unsigned QueueDepth = u8cw_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_last_o
);
  import u8cw_pkg::*;

  // Request from the classifier into the queue.
  logic   push;
  entry_t push_entry;
  logic   full;

  // Head of the queue into the serialiser.
  logic   head_valid;
  entry_t head;
  logic   pop;

  // Classify each byte, track the pending sequence, build the request.
  u8cw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  // Hold requests so that either side can stall on its own.
  u8cw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Drain the head request one byte per output handshake.
  u8cw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_last_o (string_last_o)
  );

endmodule
